@@ src/stk_isp_pkg.sv @@
`default_nettype none
package stk_isp_pkg;

  // phase codes
  localparam logic [4:0] PH_IDLE       = 5'd0;
  localparam logic [4:0] PH_SYNC_EOP   = 5'd1;
  localparam logic [4:0] PH_PARAM_ID   = 5'd2;
  localparam logic [4:0] PH_PARAM_EOP  = 5'd3;
  localparam logic [4:0] PH_SKIP       = 5'd4;
  localparam logic [4:0] PH_ENTER_EOP  = 5'd5;
  localparam logic [4:0] PH_ENTER_WAIT = 5'd6;
  localparam logic [4:0] PH_LEAVE_EOP  = 5'd7;
  localparam logic [4:0] PH_ADDR_LO    = 5'd8;
  localparam logic [4:0] PH_ADDR_HI    = 5'd9;
  localparam logic [4:0] PH_ADDR_EOP   = 5'd10;
  localparam logic [4:0] PH_UNIV_BYTES = 5'd11;
  localparam logic [4:0] PH_UNIV_EOP   = 5'd12;
  localparam logic [4:0] PH_UNIV_WAIT  = 5'd13;
  localparam logic [4:0] PH_SIZE_HI    = 5'd14;
  localparam logic [4:0] PH_SIZE_LO    = 5'd15;
  localparam logic [4:0] PH_MEMTYPE    = 5'd16;
  localparam logic [4:0] PH_DATA_A     = 5'd17;
  localparam logic [4:0] PH_DATA_B     = 5'd18;
  localparam logic [4:0] PH_CMD_WAIT   = 5'd19;
  localparam logic [4:0] PH_POLL_WAIT  = 5'd20;
  localparam logic [4:0] PH_PROG_EOP   = 5'd21;

  // what follows a finished busy poll
  localparam logic [2:0] AP_NONE      = 3'd0;
  localparam logic [2:0] AP_UNIV      = 3'd1;
  localparam logic [2:0] AP_LOAD_HIGH = 3'd2;
  localparam logic [2:0] AP_NEXT_PAIR = 3'd3;
  localparam logic [2:0] AP_PAGE_DONE = 3'd4;

  // result kinds
  localparam logic [1:0] OK_SERIAL = 2'd0;
  localparam logic [1:0] OK_ISP    = 2'd1;
  localparam logic [1:0] OK_RESET  = 2'd2;

  // host command bytes
  localparam logic [7:0] CMD_SYNC      = 8'h30;
  localparam logic [7:0] CMD_GET_PARAM = 8'h41;
  localparam logic [7:0] CMD_SET_DEV   = 8'h42;
  localparam logic [7:0] CMD_SET_DEVX  = 8'h45;
  localparam logic [7:0] CMD_ENTER     = 8'h50;
  localparam logic [7:0] CMD_LEAVE     = 8'h51;
  localparam logic [7:0] CMD_LOAD_ADDR = 8'h55;
  localparam logic [7:0] CMD_UNIVERSAL = 8'h56;
  localparam logic [7:0] CMD_PROG_PAGE = 8'h64;

  // reply bytes
  localparam logic [7:0] RSP_INSYNC   = 8'h14;
  localparam logic [7:0] RSP_OK       = 8'h10;
  localparam logic [7:0] RSP_FAILED   = 8'h11;
  localparam logic [7:0] RSP_NODEVICE = 8'h13;
  localparam logic [7:0] RSP_UNKNOWN  = 8'hFF;
  localparam logic [7:0] CRC_EOP      = 8'h20;

  // parameter ids
  localparam logic [7:0] PARM_HW    = 8'h80;
  localparam logic [7:0] PARM_SW_MJ = 8'h81;
  localparam logic [7:0] PARM_SW_MN = 8'h82;

  // ISP words and opcodes
  localparam logic [31:0] ISP_PROG_EN  = 32'hAC53_0000;
  localparam logic [31:0] ISP_POLL     = 32'hF000_0000;
  localparam logic [7:0]  ISP_ECHO     = 8'h53;
  localparam logic [7:0]  OP_LOAD_LO   = 8'h40;
  localparam logic [7:0]  OP_LOAD_HI   = 8'h48;
  localparam logic [7:0]  OP_PAGE_WR   = 8'h4C;

  // reset pin hold times
  localparam logic [8:0] MS_LEAVE   = 9'd25;
  localparam logic [8:0] MS_PULSE   = 9'd125;
  localparam logic [8:0] MS_RECOVER = 9'd425;

  // configuration register indexes
  localparam logic [1:0] REG_HW_VERSION  = 2'd0;
  localparam logic [1:0] REG_SW_MAJOR    = 2'd1;
  localparam logic [1:0] REG_SW_MINOR    = 2'd2;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd3;

  typedef struct packed {
    logic [7:0] hw_version;
    logic [7:0] sw_major;
    logic [7:0] sw_minor;
    logic [3:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  phase;
    logic [7:0]  current_command;
    logic [15:0] load_address;
    logic [7:0]  param_id;
    logic [15:0] block_size;
    logic [15:0] byte_index;
    logic [7:0]  held_data_byte;
    logic [3:0]  retry_count;
    logic [31:0] universal_word;
    logic [2:0]  after_poll;
  } state_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [31:0] spi_word;
    logic        reset_level;
    logic [8:0]  wait_ms;
    logic        last;
  } result_t;

  function automatic result_t res_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.out_kind = OK_SERIAL;
    r.tx_byte  = b;
    return r;
  endfunction

  function automatic result_t res_word(input logic [31:0] w);
    result_t r;
    r = '0;
    r.out_kind = OK_ISP;
    r.spi_word = w;
    return r;
  endfunction

  function automatic result_t res_pin(input logic lvl, input logic [8:0] ms);
    result_t r;
    r = '0;
    r.out_kind    = OK_RESET;
    r.reset_level = lvl;
    r.wait_ms     = ms;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/stk500_isp_command_engine.sv @@
// STK500v1 ISP programmer command engine, host side.
// Input channel (in_valid_i / in_stall_o): one word per item, either a host
//   serial byte (kind_i = 0, rx_byte_i) or the 4-byte reply to the ISP word
//   issued last (kind_i = 1, spi_reply_i).
// Output channel (out_valid_o / out_stall_i): result words, each a serial
//   byte to the host, a 32-bit ISP word, or a reset pin drive with a hold
//   time in ms. last_o marks the final result word of an input item; items
//   that cause no result give no output word.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data;
//   always ready. Write only while the engine is idle.
// Flow: an accepted item is registered, then stepped once the group buffer can
//   take its result group; result words are registered in the group buffer.
// Throughput: one item per cycle while the output does not stall and no group
//   of two or more words is draining. An item that yields k result words (k is
//   at most 3) holds the group buffer, so the input stalls while it drains.
// Output stall: the current result word holds; once the group buffer cannot
//   take the next group, the input register fills and in_stall_o rises.
// Reset: all parser state clears to idle awaiting a command byte, config
//   returns to its defaults, nothing is emitted and the reset pin is not
//   driven.
`default_nettype none
module stk500_isp_command_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] spi_reply_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [31:0] spi_word_o,
  output logic        reset_level_o,
  output logic [8:0]  wait_ms_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import stk_isp_pkg::*;

  cfg_t          cfg_q;
  state_t        st_q, st_d;

  // input register
  logic          in_vld_q;
  logic          kind_q;
  logic [7:0]    rx_byte_q;
  logic [31:0]   spi_reply_q;

  // result group buffer; entry 0 drives the outputs
  result_t [2:0] grp_q;
  logic [1:0]    grp_cnt_q;

  result_t [2:0] step_res;
  logic [1:0]    step_cnt;
  logic          pop, fire, in_acc;

  stk_isp_step u_step (
    .st_i        (st_q),
    .cfg_i       (cfg_q),
    .kind_i      (kind_q),
    .rx_byte_i   (rx_byte_q),
    .spi_reply_i (spi_reply_q),
    .st_o        (st_d),
    .res_o       (step_res),
    .cnt_o       (step_cnt)
  );

  assign pop  = out_valid_o && !out_stall_i;
  // step when the group buffer is empty or drains its last word now
  assign fire = in_vld_q && ((grp_cnt_q == 2'd0) || ((grp_cnt_q == 2'd1) && pop));
  assign in_stall_o = in_vld_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hw_version  <= 8'd1;
      cfg_q.sw_major    <= 8'd0;
      cfg_q.sw_minor    <= 8'd1;
      cfg_q.retry_limit <= 4'd5;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HW_VERSION:  cfg_q.hw_version  <= cfg_data_i;
        REG_SW_MAJOR:    cfg_q.sw_major    <= cfg_data_i;
        REG_SW_MINOR:    cfg_q.sw_minor    <= cfg_data_i;
        REG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      in_vld_q  <= 1'b0;
      grp_cnt_q <= 2'd0;
    end else begin
      if (fire) st_q <= st_d;
      if (in_acc)    in_vld_q <= 1'b1;
      else if (fire) in_vld_q <= 1'b0;
      if (fire)     grp_cnt_q <= step_cnt;
      else if (pop) grp_cnt_q <= grp_cnt_q - 2'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q      <= kind_i;
      rx_byte_q   <= rx_byte_i;
      spi_reply_q <= spi_reply_i;
    end
    if (fire) begin
      grp_q <= step_res;
    end else if (pop) begin
      grp_q[0] <= grp_q[1];
      grp_q[1] <= grp_q[2];
    end
  end

  assign out_valid_o   = (grp_cnt_q != 2'd0);
  assign out_kind_o    = grp_q[0].out_kind;
  assign tx_byte_o     = grp_q[0].tx_byte;
  assign spi_word_o    = grp_q[0].spi_word;
  assign reset_level_o = grp_q[0].reset_level;
  assign wait_ms_o     = grp_q[0].wait_ms;
  assign last_o        = grp_q[0].last;

endmodule
`default_nettype wire

@@ src/stk_isp_step.sv @@
`default_nettype none
module stk_isp_step (
  input  stk_isp_pkg::state_t        st_i,
  input  stk_isp_pkg::cfg_t          cfg_i,
  input  logic                       kind_i,
  input  logic [7:0]                 rx_byte_i,
  input  logic [31:0]                spi_reply_i,
  output stk_isp_pkg::state_t        st_o,
  output stk_isp_pkg::result_t [2:0] res_o,
  output logic [1:0]                 cnt_o
);
  import stk_isp_pkg::*;

  state_t          st;
  result_t [2:0]   res;
  logic [1:0]      cnt;
  logic [7:0]      lw_addr;
  logic [15:0]     idx_inc;
  logic [16:0]     idx_next;
  logic [3:0]      retry_inc;

  // low address byte of the current byte pair
  assign lw_addr   = 8'(st_i.load_address[7:0] + st_i.byte_index[8:1]);
  assign idx_inc   = 16'(st_i.byte_index + 16'd1);
  assign idx_next  = {1'b0, st_i.byte_index} + 17'd2;
  assign retry_inc = 4'(st_i.retry_count + 4'd1);

  always_comb begin
    st  = st_i;
    res = '0;
    cnt = 2'd0;
    if (!kind_i) begin
      case (st_i.phase)
        PH_IDLE: begin
          st.current_command = rx_byte_i;
          case (rx_byte_i)
            CMD_SYNC:                 st.phase = PH_SYNC_EOP;
            CMD_GET_PARAM:            st.phase = PH_PARAM_ID;
            CMD_SET_DEV, CMD_SET_DEVX: st.phase = PH_SKIP;
            CMD_ENTER:                st.phase = PH_ENTER_EOP;
            CMD_LEAVE:                st.phase = PH_LEAVE_EOP;
            CMD_LOAD_ADDR:            st.phase = PH_ADDR_LO;
            CMD_UNIVERSAL: begin
              st.byte_index     = '0;
              st.universal_word = '0;
              st.phase          = PH_UNIV_BYTES;
            end
            CMD_PROG_PAGE:            st.phase = PH_SIZE_HI;
            default: ;
          endcase
        end
        PH_SYNC_EOP, PH_ADDR_EOP, PH_PROG_EOP: begin
          res[0]   = res_byte(RSP_INSYNC);
          res[1]   = res_byte(RSP_OK);
          cnt      = 2'd2;
          st.phase = PH_IDLE;
        end
        PH_PARAM_ID: begin
          st.param_id = rx_byte_i;
          st.phase    = PH_PARAM_EOP;
        end
        PH_PARAM_EOP: begin
          res[0] = res_byte(RSP_INSYNC);
          res[2] = res_byte(RSP_OK);
          case (st_i.param_id)
            PARM_HW:    res[1] = res_byte(cfg_i.hw_version);
            PARM_SW_MJ: res[1] = res_byte(cfg_i.sw_major);
            PARM_SW_MN: res[1] = res_byte(cfg_i.sw_minor);
            default: begin
              res[1] = res_byte(RSP_UNKNOWN);
              res[2] = res_byte(RSP_FAILED);
            end
          endcase
          cnt      = 2'd3;
          st.phase = PH_IDLE;
        end
        PH_SKIP: begin
          if (rx_byte_i == CRC_EOP) begin
            res[0]   = res_byte(RSP_INSYNC);
            res[1]   = res_byte(RSP_OK);
            cnt      = 2'd2;
            st.phase = PH_IDLE;
          end
        end
        PH_ENTER_EOP: begin
          res[0]         = res_byte(RSP_INSYNC);
          cnt            = 2'd2;
          st.retry_count = '0;
          if (cfg_i.retry_limit == '0) begin
            res[1]   = res_byte(RSP_NODEVICE);
            st.phase = PH_IDLE;
          end else begin
            res[1]   = res_word(ISP_PROG_EN);
            st.phase = PH_ENTER_WAIT;
          end
        end
        PH_LEAVE_EOP: begin
          res[0]   = res_byte(RSP_INSYNC);
          res[1]   = res_pin(1'b1, MS_LEAVE);
          res[2]   = res_byte(RSP_OK);
          cnt      = 2'd3;
          st.phase = PH_IDLE;
        end
        PH_ADDR_LO: begin
          st.load_address = {8'd0, rx_byte_i};
          st.phase        = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          st.load_address = st_i.load_address | {rx_byte_i, 8'd0};
          st.phase        = PH_ADDR_EOP;
        end
        PH_UNIV_BYTES: begin
          st.universal_word = {st_i.universal_word[23:0], rx_byte_i};
          st.byte_index     = idx_inc;
          if (idx_inc >= 16'd4) st.phase = PH_UNIV_EOP;
        end
        PH_UNIV_EOP: begin
          res[0]   = res_byte(RSP_INSYNC);
          res[1]   = res_word(st_i.universal_word);
          cnt      = 2'd2;
          st.phase = PH_UNIV_WAIT;
        end
        PH_SIZE_HI: begin
          st.block_size = {rx_byte_i, 8'd0};
          st.phase      = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          st.block_size = st_i.block_size | {8'd0, rx_byte_i};
          st.phase      = PH_MEMTYPE;
        end
        PH_MEMTYPE: begin
          st.byte_index = '0;
          if (st_i.block_size == '0) begin
            res[0]        = res_word({OP_PAGE_WR, st_i.load_address, 8'd0});
            cnt           = 2'd1;
            st.after_poll = AP_PAGE_DONE;
            st.phase      = PH_CMD_WAIT;
          end else begin
            st.phase = PH_DATA_A;
          end
        end
        PH_DATA_A: begin
          st.held_data_byte = rx_byte_i;
          st.phase          = PH_DATA_B;
        end
        PH_DATA_B: begin
          res[0]            = res_word({OP_LOAD_LO, 8'd0, lw_addr, st_i.held_data_byte});
          cnt               = 2'd1;
          st.after_poll     = AP_LOAD_HIGH;
          st.phase          = PH_CMD_WAIT;
          st.held_data_byte = rx_byte_i;
        end
        default: ;
      endcase
    end else begin
      case (st_i.phase)
        PH_ENTER_WAIT: begin
          if (spi_reply_i[15:8] == ISP_ECHO) begin
            res[0]   = res_byte(RSP_OK);
            cnt      = 2'd1;
            st.phase = PH_IDLE;
          end else begin
            st.retry_count = retry_inc;
            res[0]         = res_pin(1'b1, MS_PULSE);
            res[1]         = res_pin(1'b0, MS_RECOVER);
            cnt            = 2'd3;
            if (retry_inc >= cfg_i.retry_limit || retry_inc == '0) begin
              res[2]   = res_byte(RSP_NODEVICE);
              st.phase = PH_IDLE;
            end else begin
              res[2]   = res_word(ISP_PROG_EN);
              st.phase = PH_ENTER_WAIT;
            end
          end
        end
        PH_UNIV_WAIT: begin
          res[0]        = res_byte(spi_reply_i[7:0]);
          res[1]        = res_word(ISP_POLL);
          cnt           = 2'd2;
          st.after_poll = AP_UNIV;
          st.phase      = PH_POLL_WAIT;
        end
        PH_CMD_WAIT: begin
          res[0]   = res_word(ISP_POLL);
          cnt      = 2'd1;
          st.phase = PH_POLL_WAIT;
        end
        PH_POLL_WAIT: begin
          if (spi_reply_i[0]) begin
            res[0] = res_word(ISP_POLL);
            cnt    = 2'd1;
          end else begin
            st.after_poll = AP_NONE;
            st.phase      = PH_IDLE;
            case (st_i.after_poll)
              AP_UNIV: begin
                res[0] = res_byte(RSP_OK);
                cnt    = 2'd1;
              end
              AP_LOAD_HIGH: begin
                res[0]        = res_word({OP_LOAD_HI, 8'd0, lw_addr, st_i.held_data_byte});
                cnt           = 2'd1;
                st.after_poll = AP_NEXT_PAIR;
                st.phase      = PH_CMD_WAIT;
              end
              AP_NEXT_PAIR: begin
                st.byte_index = idx_next[15:0];
                if (idx_next < {1'b0, st_i.block_size}) begin
                  st.phase = PH_DATA_A;
                end else begin
                  res[0]        = res_word({OP_PAGE_WR, st_i.load_address, 8'd0});
                  cnt           = 2'd1;
                  st.after_poll = AP_PAGE_DONE;
                  st.phase      = PH_CMD_WAIT;
                end
              end
              AP_PAGE_DONE: st.phase = PH_PROG_EOP;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // mark the final word of the group
  always_comb begin
    res_o         = res;
    res_o[0].last = (cnt == 2'd1);
    res_o[1].last = (cnt == 2'd2);
    res_o[2].last = (cnt == 2'd3);
  end

  assign st_o  = st;
  assign cnt_o = cnt;

endmodule
`default_nettype wire
